FILE: design/lkd_pkg.sv
// Shared types, constants and decode function for the ladder keypad debouncer.
package lkd_pkg;

   localparam int KEY_COUNT   = 5;
   localparam int SAMPLE_W    = 10;
   localparam int COUNT_W     = 8;
   localparam int KEY_W       = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // no key selected
   localparam logic [KEY_W-1:0] KEY_NONE = KEY_W'(KEY_COUNT);

   // register indexes
   localparam logic [2:0] REG_THR0    = 3'd0;
   localparam logic [2:0] REG_THR1    = 3'd1;
   localparam logic [2:0] REG_THR2    = 3'd2;
   localparam logic [2:0] REG_THR3    = 3'd3;
   localparam logic [2:0] REG_THR4    = 3'd4;
   localparam logic [2:0] REG_CAP     = 3'd5;
   localparam logic [2:0] REG_PRESS   = 3'd6;
   localparam logic [2:0] REG_RELEASE = 3'd7;

   // reset values
   localparam logic [SAMPLE_W-1:0] THR0_RST    = 10'd50;
   localparam logic [SAMPLE_W-1:0] THR1_RST    = 10'd200;
   localparam logic [SAMPLE_W-1:0] THR2_RST    = 10'd400;
   localparam logic [SAMPLE_W-1:0] THR3_RST    = 10'd600;
   localparam logic [SAMPLE_W-1:0] THR4_RST    = 10'd800;
   localparam logic [COUNT_W-1:0]  CAP_RST     = 8'd15;
   localparam logic [COUNT_W-1:0]  PRESS_RST   = 8'd10;
   localparam logic [COUNT_W-1:0]  RELEASE_RST = 8'd3;

   typedef logic [KEY_COUNT-1:0][SAMPLE_W-1:0] thr_array_type;

   // per-key step control from the top level
   typedef struct packed {
      logic step;
      logic sel;
      logic ack;
   } key_ctl_type;

   // shared counter levels
   typedef struct packed {
      logic [COUNT_W-1:0] cap_level;
      logic [COUNT_W-1:0] press_level;
      logic [COUNT_W-1:0] rel_level;
   } key_levels_type;

   // key status after the current step
   typedef struct packed {
      logic held;
      logic flag;
   } key_status_type;

   // lowest key whose threshold exceeds the sample, else KEY_NONE
   function automatic logic [KEY_W-1:0] decode_key(input logic [SAMPLE_W-1:0] sample,
                                                   input thr_array_type thr);
      logic [KEY_W-1:0] k;
      k = KEY_NONE;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (sample < thr[i]) begin
            k = KEY_W'(i);
         end
      end
      return k;
   endfunction

endpackage

FILE: design/lkd_key_cell.sv
// One key's integrating counter with held bit and press flag.
module lkd_key_cell
   import lkd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  key_ctl_type    ctl,
   input  key_levels_type levels,
   output key_status_type status_in
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               held_ff;
   logic               held_in;
   logic               flag_ff;
   logic               flag_in;
   logic [COUNT_W-1:0] count_up;
   logic [COUNT_W-1:0] count_dn;

   assign count_up = count_ff + COUNT_W'(1);
   assign count_dn = count_ff - COUNT_W'(1);

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      flag_in  = flag_ff & ~ctl.ack;   // ack lands before the update
      if (ctl.sel) begin
         if (count_ff < levels.cap_level) begin
            count_in = count_up;
            if ((count_up > levels.press_level) && !held_ff) begin
               held_in = 1'b1;
               flag_in = 1'b1;
            end
         end
      end else if (count_ff != '0) begin
         count_in = count_dn;
         flag_in  = 1'b0;
         if (count_dn < levels.rel_level) begin
            held_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= 1'b0;
         flag_ff  <= 1'b0;
      end else if (ctl.step) begin
         count_ff <= count_in;
         held_ff  <= held_in;
         flag_ff  <= flag_in;
      end
   end

   assign status_in.held = held_in;
   assign status_in.flag = flag_in;

endmodule

FILE: design/ladder_keypad_debouncer_core.sv
// Ladder keypad debouncer top level: CSRs, request stage, key cells, response register.
// An accepted request is held in the request register, then moves into the response register.
// Throughput: 1 request per cycle while the response is taken;
// the key cell update is a single compare/add per key.
// A stalled response holds only the response register; one more request is buffered behind it.
// Reset (synchronous, active high) clears counters, held bits, flags and valids,
// and loads the CSRs with their default thresholds and levels.
module ladder_keypad_debouncer_core
   import lkd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_adc_sample,
   input  logic [KEY_COUNT-1:0]  req_ack_mask,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KEY_W-1:0]      rsp_decoded_key,
   output logic [KEY_COUNT-1:0]  rsp_held_mask,
   output logic [KEY_COUNT-1:0]  rsp_press_flags,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   thr_array_type      thr_ff;
   thr_array_type      thr_in;
   logic [COUNT_W-1:0] cap_ff;
   logic [COUNT_W-1:0] cap_in;
   logic [COUNT_W-1:0] press_ff;
   logic [COUNT_W-1:0] press_in;
   logic [COUNT_W-1:0] rel_ff;
   logic [COUNT_W-1:0] rel_in;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      thr_in   = thr_ff;
      cap_in   = cap_ff;
      press_in = press_ff;
      rel_in   = rel_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_THR0:    thr_in[0] = csr_pwdata[SAMPLE_W-1:0];
            REG_THR1:    thr_in[1] = csr_pwdata[SAMPLE_W-1:0];
            REG_THR2:    thr_in[2] = csr_pwdata[SAMPLE_W-1:0];
            REG_THR3:    thr_in[3] = csr_pwdata[SAMPLE_W-1:0];
            REG_THR4:    thr_in[4] = csr_pwdata[SAMPLE_W-1:0];
            REG_CAP:     cap_in    = csr_pwdata[COUNT_W-1:0];
            REG_PRESS:   press_in  = csr_pwdata[COUNT_W-1:0];
            REG_RELEASE: rel_in    = csr_pwdata[COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0] <= THR0_RST;
         thr_ff[1] <= THR1_RST;
         thr_ff[2] <= THR2_RST;
         thr_ff[3] <= THR3_RST;
         thr_ff[4] <= THR4_RST;
         cap_ff    <= CAP_RST;
         press_ff  <= PRESS_RST;
         rel_ff    <= RELEASE_RST;
      end else begin
         thr_ff    <= thr_in;
         cap_ff    <= cap_in;
         press_ff  <= press_in;
         rel_ff    <= rel_in;
      end
   end

   // readback mux
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_THR0:    csr_prdata = CSR_DATA_W'(thr_ff[0]);
         REG_THR1:    csr_prdata = CSR_DATA_W'(thr_ff[1]);
         REG_THR2:    csr_prdata = CSR_DATA_W'(thr_ff[2]);
         REG_THR3:    csr_prdata = CSR_DATA_W'(thr_ff[3]);
         REG_THR4:    csr_prdata = CSR_DATA_W'(thr_ff[4]);
         REG_CAP:     csr_prdata = CSR_DATA_W'(cap_ff);
         REG_PRESS:   csr_prdata = CSR_DATA_W'(press_ff);
         REG_RELEASE: csr_prdata = CSR_DATA_W'(rel_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Request stage: registers the incoming request
   // ------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   logic [KEY_COUNT-1:0] s1_ack_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 advance;
   logic                 req_take;

   // stage 1 moves into the response register when that register is free or draining
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_adc_sample;
         s1_ack_ff    <= req_ack_mask;
      end
   end

   // ------------------------------------------------------------------
   // Decode and key update; key state commits when the request advances
   // ------------------------------------------------------------------
   logic [KEY_W-1:0]     sel_key;
   key_levels_type       levels;
   key_status_type       status [KEY_COUNT];
   logic [KEY_COUNT-1:0] held_next;
   logic [KEY_COUNT-1:0] flag_next;

   assign sel_key            = decode_key(s1_sample_ff, thr_ff);
   assign levels.cap_level   = cap_ff;
   assign levels.press_level = press_ff;
   assign levels.rel_level   = rel_ff;

   for (genvar g = 0; g < KEY_COUNT; g++) begin : g_key
      key_ctl_type ctl;
      assign ctl.step = advance;
      assign ctl.sel  = (sel_key == KEY_W'(g));
      assign ctl.ack  = s1_ack_ff[g];

      lkd_key_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .levels    (levels),
         .status_in (status[g])
      );

      assign held_next[g] = status[g].held;
      assign flag_next[g] = status[g].flag;
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [KEY_COUNT-1:0] rsp_held_ff;
   logic [KEY_COUNT-1:0] rsp_flags_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_key_ff   <= sel_key;
         rsp_held_ff  <= held_next;
         rsp_flags_ff <= flag_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_decoded_key = rsp_key_ff;
   assign rsp_held_mask   = rsp_held_ff;
   assign rsp_press_flags = rsp_flags_ff;

endmodule

FILE: design/lkd_checker.sv
// Port-level assertions for the ladder keypad debouncer, bound to the top level.
module lkd_checker
   import lkd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [SAMPLE_W-1:0]   req_adc_sample,
   input logic [KEY_COUNT-1:0]  req_ack_mask,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [KEY_W-1:0]      rsp_decoded_key,
   input logic [KEY_COUNT-1:0]  rsp_held_mask,
   input logic [KEY_COUNT-1:0]  rsp_press_flags,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a key code beyond the none code never leaves
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decoded_key <= KEY_NONE))
      else $error("decoded key out of range");

   // a pending press flag always belongs to a held key
   a_flag_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_press_flags & ~rsp_held_mask) == '0))
      else $error("press flag without held bit");

   // with the response register empty the block takes requests
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decoded_key)
         && $stable(rsp_held_mask) && $stable(rsp_press_flags))
      else $error("stalled response changed");

endmodule

bind ladder_keypad_debouncer_core lkd_checker u_lkd_checker (.*);

FILE: tb/ladder_keypad_debouncer_core_tb.sv
// Self-checking testbench for the ladder keypad debouncer core.
`timescale 1ns / 1ps

module ladder_keypad_debouncer_core_tb
   import lkd_pkg::*;
();

   localparam int NUM_REGS        = int'(REG_RELEASE) + 1;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int LAST_PHASE      = 9;
   localparam int PAUSE_PHASE     = 6;   // sender drains mid-phase here
   localparam int LONG_HOLD       = 250; // receiver back-pressure stretch, cycles
   localparam int SETTLE_CYCLES   = 4;   // request reg + response reg, with margin
   localparam int LIMIT_CYCLES    = 300000;

   // one response of the block
   typedef struct packed {
      logic [KEY_W-1:0]     decoded;
      logic [KEY_COUNT-1:0] held;
      logic [KEY_COUNT-1:0] flags;
   } key_result_type;

   // directed stimulus row; typed rows carry a hand-written response
   typedef struct packed {
      logic [SAMPLE_W-1:0]  adc;
      logic [KEY_COUNT-1:0] ack;
      logic [7:0]           reps;
      logic                 typed;
      key_result_type       res;
   } stim_row_type;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SLOW, RX_EVERY_THIRD} rx_pattern_type;

   // DUT ports; every input known from time zero
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_adc_sample = '0;
   logic [KEY_COUNT-1:0]  req_ack_mask   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [KEY_W-1:0]      rsp_decoded_key;
   logic [KEY_COUNT-1:0]  rsp_held_mask;
   logic [KEY_COUNT-1:0]  rsp_press_flags;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // debouncer state mirrored by the predictor
   logic [SAMPLE_W-1:0]   thr_q [KEY_COUNT];
   logic [COUNT_W-1:0]    cap_q, press_q, rel_q;
   logic [COUNT_W-1:0]    cnt_q [KEY_COUNT];
   logic [KEY_COUNT-1:0]  held_q, flag_q;

   key_result_type        pending_results [$];
   key_result_type        head_res;
   int                    error_count  = 0;
   int                    results_seen = 0;
   int                    cycle_count  = 0;

   // receiver state
   int                    hold_left    = 0;
   int                    next_hold_at = 300;
   int                    mode_left    = 0;
   rx_pattern_type        rx_pattern   = RX_ALWAYS;

   // directed table: extremes, every threshold boundary, ack ordering
   stim_row_type directed_rows [16] = '{
      '{10'd1023, 5'd0,  8'd1, 1'b1, '{KEY_NONE, 5'd0, 5'd0}},  // nothing pressed
      '{10'd0,    5'd31, 8'd1, 1'b1, '{3'd0, 5'd0, 5'd0}},      // first count on key 0
      '{10'd0,    5'd0,  8'd9, 1'b0, '0},                       // count up to press level
      '{10'd0,    5'd1,  8'd1, 1'b1, '{3'd0, 5'b00001, 5'b00001}}, // press beats same-item ack
      '{10'd50,   5'd0,  8'd1, 1'b0, '0},                       // key 0 boundary
      '{10'd199,  5'd0,  8'd1, 1'b0, '0},
      '{10'd200,  5'd0,  8'd1, 1'b0, '0},
      '{10'd399,  5'd0,  8'd1, 1'b0, '0},
      '{10'd400,  5'd0,  8'd1, 1'b0, '0},
      '{10'd599,  5'd0,  8'd1, 1'b0, '0},
      '{10'd600,  5'd0,  8'd1, 1'b0, '0},
      '{10'd799,  5'd0,  8'd1, 1'b0, '0},
      '{10'd800,  5'd0,  8'd1, 1'b0, '0},                       // at or above all thresholds
      '{10'd1023, 5'd0,  8'd1, 1'b0, '0},
      '{10'd0,    5'd31, 8'd3, 1'b0, '0},
      '{10'd1023, 5'd31, 8'd1, 1'b0, '0}
   };

   ladder_keypad_debouncer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_adc_sample  (req_adc_sample),
      .req_ack_mask    (req_ack_mask),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_decoded_key (rsp_decoded_key),
      .rsp_held_mask   (rsp_held_mask),
      .rsp_press_flags (rsp_press_flags),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void reset_debouncer();
      thr_q[0] = THR0_RST;
      thr_q[1] = THR1_RST;
      thr_q[2] = THR2_RST;
      thr_q[3] = THR3_RST;
      thr_q[4] = THR4_RST;
      cap_q    = CAP_RST;
      press_q  = PRESS_RST;
      rel_q    = RELEASE_RST;
      for (int i = 0; i < KEY_COUNT; i++) cnt_q[i] = '0;
      held_q = '0;
      flag_q = '0;
   endfunction

   function automatic void set_register(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         REG_THR0, REG_THR1, REG_THR2, REG_THR3, REG_THR4: begin
            thr_q[idx] = val[SAMPLE_W-1:0];
         end
         REG_CAP:     cap_q   = val[COUNT_W-1:0];
         REG_PRESS:   press_q = val[COUNT_W-1:0];
         REG_RELEASE: rel_q   = val[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // one ADC tick: ack first, then first-match decode, then integrate every key
   function automatic key_result_type debounce_step(input logic [SAMPLE_W-1:0] adc,
                                                    input logic [KEY_COUNT-1:0] ack);
      key_result_type   r;
      logic [KEY_W-1:0] sel;
      bit               found;
      flag_q = flag_q & ~ack;
      sel    = KEY_NONE;
      found  = 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (!found && adc < thr_q[k]) begin
            sel   = KEY_W'(k);
            found = 1'b1;
         end
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (sel == KEY_W'(k)) begin
            // a counter at or above the cap is frozen while selected
            if (cnt_q[k] < cap_q) begin
               cnt_q[k] = cnt_q[k] + 1'b1;
               if (cnt_q[k] > press_q && !held_q[k]) begin
                  flag_q[k] = 1'b1;
                  held_q[k] = 1'b1;
               end
            end
         end else if (cnt_q[k] != '0) begin
            flag_q[k] = 1'b0;
            cnt_q[k]  = cnt_q[k] - 1'b1;
            if (cnt_q[k] < rel_q) held_q[k] = 1'b0;
         end
      end
      r.decoded = sel;
      r.held    = held_q;
      r.flags   = flag_q;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one request; hold it until accepted, then log its expected response
   task automatic send_request(input logic [SAMPLE_W-1:0] adc, input logic [KEY_COUNT-1:0] ack,
                               input logic typed, input key_result_type typed_res);
      key_result_type predicted;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_adc_sample <= adc;
      req_ack_mask   <= ack;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = debounce_step(adc, ack);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   task automatic idle_for(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // stop sending and wait until every response is back and the pipe is empty
   task automatic drain();
      idle_for(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write then read-back; upper junk bits must be dropped by the register
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] wdata;
      mask  = (idx <= REG_THR4) ? 32'h3FF : 32'hFF;
      wdata = $urandom_range(0, 1) ? (($urandom & ~mask) | (value & mask)) : (value & mask);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      set_register(idx, wdata & mask);
      // read setup
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== (wdata & mask)) begin
         $display("%0t: register %0d readback expected %0h got %0h",
                  $time, idx, wdata & mask, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- settings

   task automatic pick_settings(input int phase, output logic [31:0] cfg [NUM_REGS]);
      int c;
      case (phase)
         1: begin  // evenly spread keys, quick press
            for (int k = 0; k < KEY_COUNT; k++) cfg[k] = 100 + 200 * k;
            cfg[REG_CAP] = 30;  cfg[REG_PRESS] = 5;   cfg[REG_RELEASE] = 2;
         end
         2: begin  // cap lowered under counters already high
            for (int k = 0; k < KEY_COUNT; k++) cfg[k] = 100 + 200 * k;
            cfg[REG_CAP] = 2;   cfg[REG_PRESS] = 0;   cfg[REG_RELEASE] = 1;
         end
         3: begin  // cap of zero: no key can newly become held
            cfg[REG_THR0] = 1023; cfg[REG_THR1] = 1023;
            cfg[REG_THR2] = 0;    cfg[REG_THR3] = 0;    cfg[REG_THR4] = 0;
            cfg[REG_CAP] = 0;   cfg[REG_PRESS] = 255; cfg[REG_RELEASE] = 255;
         end
         4: begin  // every sample decodes to none
            for (int k = 0; k < KEY_COUNT; k++) cfg[k] = 0;
            cfg[REG_CAP] = 255; cfg[REG_PRESS] = 254; cfg[REG_RELEASE] = 0;
         end
         5: begin  // unordered thresholds, instant press, release at once
            for (int k = 0; k < KEY_COUNT; k++) cfg[k] = $urandom_range(0, 1023);
            cfg[REG_CAP] = 255; cfg[REG_PRESS] = 0;   cfg[REG_RELEASE] = 255;
         end
         default: begin
            for (int k = 0; k < KEY_COUNT; k++) cfg[k] = $urandom_range(0, 1023);
            c = $urandom_range(1, 24);
            cfg[REG_CAP]     = c;
            cfg[REG_PRESS]   = $urandom_range(0, c);
            cfg[REG_RELEASE] = $urandom_range(0, cfg[REG_PRESS] + 1);
         end
      endcase
   endtask

   // sample that sits on or next to a threshold, or at the rails, or anywhere
   function automatic logic [SAMPLE_W-1:0] pick_level();
      int k;
      k = $urandom_range(0, KEY_COUNT - 1);
      case ($urandom_range(0, 9))
         0, 1, 2: return thr_q[k] - 1'b1;
         3, 4:    return thr_q[k];
         5:       return '0;
         6:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // random part: runs of a steady ladder level with some noise, sent in bursts
   task automatic run_random(input int n, input int phase);
      int                   burst_left;
      int                   run_left;
      int                   gap;
      logic [SAMPLE_W-1:0]  run_adc;
      logic [SAMPLE_W-1:0]  adc;
      logic [KEY_COUNT-1:0] ack;
      burst_left = 0;
      run_left   = 0;
      run_adc    = '0;
      for (int i = 0; i < n; i++) begin
         if (phase == PAUSE_PHASE && i == n / 2) drain();
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            if (gap > 0) idle_for(gap);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
         if (run_left == 0) begin
            run_adc  = pick_level();
            // mostly short holds, now and then one long enough to hit a high cap
            run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 40);
         end
         run_left--;
         adc = ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom) : run_adc;
         case ($urandom_range(0, 19))
            0, 1, 2: ack = flag_q;                   // consumer takes pending presses
            3, 4, 5: ack = KEY_COUNT'($urandom);
            default: ack = '0;
         endcase
         send_request(adc, ack, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // back-pressure: random patterns, plus a long hold every 700 responses
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (results_seen >= next_hold_at) begin
         hold_left    = LONG_HOLD - 1;
         next_hold_at = next_hold_at + 700;
         rsp_ready   <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
         end
         mode_left--;
         case (rx_pattern)
            RX_ALWAYS:      rsp_ready <= 1'b1;
            RX_HALF:        rsp_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:        rsp_ready <= ($urandom_range(0, 3) == 0);
            RX_EVERY_THIRD: rsp_ready <= (cycle_count % 3 == 0);
            default:        rsp_ready <= 1'b1;
         endcase
      end
   end

   // response checker: in-order compare against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response key %0d held %b flags %b",
                     $time, rsp_decoded_key, rsp_held_mask, rsp_press_flags);
            error_count++;
         end else begin
            head_res = pending_results.pop_front();
            if (rsp_decoded_key !== head_res.decoded) begin
               $display("%0t: decoded_key expected %0d got %0d",
                        $time, head_res.decoded, rsp_decoded_key);
               error_count++;
            end
            if (rsp_held_mask !== head_res.held) begin
               $display("%0t: held_mask expected %b got %b",
                        $time, head_res.held, rsp_held_mask);
               error_count++;
            end
            if (rsp_press_flags !== head_res.flags) begin
               $display("%0t: press_flags expected %b got %b",
                        $time, head_res.flags, rsp_press_flags);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      logic [31:0] cfg [NUM_REGS];
      reset_debouncer();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk at reset settings
      foreach (directed_rows[r]) begin
         for (int n = 0; n < directed_rows[r].reps; n++) begin
            send_request(directed_rows[r].adc, directed_rows[r].ack,
                         directed_rows[r].typed, directed_rows[r].res);
         end
      end

      // phase 0 keeps reset settings; later phases reprogram all registers while idle
      for (int phase = 0; phase <= LAST_PHASE; phase++) begin
         if (phase > 0) begin
            drain();
            pick_settings(phase, cfg);
            for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), cfg[r]);
         end
         run_random(ITEMS_PER_PHASE, phase);
      end

      // wait out the pipe, then idle on to catch stray responses
      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
